FILE: hdl/xdbt_pkg.sv
`timescale 1ns / 1ps
package xdbt_pkg;

    localparam int ID_BITS_DEF      = 64;
    localparam int BUCKET_DEPTH_DEF = 8;
    localparam logic [31:0] REFRESH_AGE_RST = 32'd900;

    // status codes
    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_REFRESH  = 2'd3;

    // configuration register indexes
    localparam logic [0:0] CFG_SELF_ID     = 1'd0;
    localparam logic [0:0] CFG_REFRESH_AGE = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZSCAN,
        S_SEARCH,
        S_CHECK,
        S_WRITE,
        S_REFRESH,
        S_DONE,
        S_CLEAR
    } state_t;

endpackage

FILE: hdl/xdbt_lzc.sv
`timescale 1ns / 1ps
// Iterative leading-zero counter: examines 8 bits per cycle from the top.
module xdbt_lzc #(
    parameter int ID_BITS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ID_BITS-1:0]         distance,
    output logic                       done,
    output logic [$clog2(ID_BITS)-1:0] zeros
);
    localparam int IW    = $clog2(ID_BITS);
    localparam int CHUNK = 8;
    localparam int STEPS = (ID_BITS + CHUNK - 1) / CHUNK;
    localparam int PW    = STEPS * CHUNK;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int ZW    = $clog2(PW + 1);

    logic [PW-1:0]  shv_reg, shv_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [ZW-1:0]  z_reg, z_next;
    logic           busy_reg, busy_next;
    logic           hit_reg, hit_next;
    logic [3:0]     lead;
    logic           found;

    // leading zeros within the top byte
    always_comb
    begin
        lead  = 4'd8;
        found = 1'b0;
        for (int i = 0; i < CHUNK; i++)
        begin
            if (!found && shv_reg[PW-1-i])
            begin
                lead  = 4'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        shv_next  = shv_reg;
        cnt_next  = cnt_reg;
        z_next    = z_reg;
        busy_next = busy_reg;
        hit_next  = hit_reg;
        if (start)
        begin
            shv_next  = {distance, {(PW-ID_BITS){1'b0}}};
            cnt_next  = '0;
            z_next    = '0;
            busy_next = 1'b1;
            hit_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!hit_reg)
            begin
                z_next = z_reg + ZW'(lead);
                if (found)
                    hit_next = 1'b1;
            end
            shv_next = shv_reg << CHUNK;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            hit_reg  <= 1'b0;
            cnt_reg  <= '0;
            z_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            hit_reg  <= hit_next;
            cnt_reg  <= cnt_next;
            z_reg    <= z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shv_reg <= shv_next;
    end

    logic busy_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_d_reg <= 1'b0;
        else
            busy_d_reg <= busy_reg;
    end

    assign done  = busy_d_reg && !busy_reg;
    // zero distance counts as all zeros: clamp to last bucket
    assign zeros = (z_reg >= ZW'(ID_BITS)) ? IW'(ID_BITS - 1) : z_reg[IW-1:0];

endmodule

FILE: hdl/xor_distance_bucket_table_unit.sv
`timescale 1ns / 1ps
// XOR-distance bucket routing table.
// Input channel: in_valid/in_stall with mode, node_id, ip_addr, port_num,
// peer_seed, now. Output channel: out_valid/out_stall with status,
// bucket_index, table_size, one result per accepted item.
// Config channel: cfg_valid/cfg_ready, cfg_index 0 = self_id,
// 1 = refresh_age; write only while idle.
// Update: the leading-zero unit picks the bucket, then each stored entry is
// compared by a registered read of the entry memory, then the single shared
// identifier compare; then come the write and done states.
// Refresh: one bucket per cycle.
// The input stalls while an item is in work or a result is waiting; the
// next item is taken in the cycle after the result transfer at the earliest.
// Reset clears stats and self_id and sets refresh_age to 900, then a clear pass
// over every bucket zeroes the bucket fills with the input stalled; entry memory
// holds no reset value. A stalled result simply holds on the outputs.
module xor_distance_bucket_table_unit
    import xdbt_pkg::*;
#(
    parameter int ID_BITS      = xdbt_pkg::ID_BITS_DEF,
    parameter int BUCKET_DEPTH = xdbt_pkg::BUCKET_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [63:0] node_id,
    input  logic [31:0] ip_addr,
    input  logic [15:0] port_num,
    input  logic [7:0]  peer_seed,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [5:0]  bucket_index,
    output logic [12:0] table_size
);
    localparam int IW    = $clog2(ID_BITS);
    localparam int DW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOTS = ID_BITS * BUCKET_DEPTH;
    localparam int AW    = $clog2(SLOTS);

    state_t state_reg, state_next;

    logic [63:0] self_id_reg;
    logic [31:0] refresh_age_reg;
    logic [12:0] total_reg;

    // bucket memories
    logic [FW-1:0] fill_mem  [ID_BITS];
    logic [31:0]   stamp_mem [ID_BITS];
    logic [FW-1:0] fill_rd_reg;
    logic [31:0]   stamp_rd_reg;
    logic [IW-1:0] brd_addr, fill_waddr, stamp_waddr;
    logic [FW-1:0] fill_wdata;
    logic          fill_we, stamp_we;
    logic [IW-1:0] ridx_d_reg;
    logic          rvalid_d_reg;
    logic          refresh_hit;

    // entry memories
    logic [ID_BITS-1:0] ident_mem [SLOTS];
    logic [47:0]        addr_mem  [SLOTS];
    logic [7:0]         seed_mem  [SLOTS];
    logic [31:0]        seen_mem  [SLOTS];
    logic [ID_BITS-1:0] ident_rd_reg;

    // latched item
    logic [ID_BITS-1:0] id_reg;
    logic [47:0]        addr_reg;
    logic [7:0]         seed_reg;
    logic [31:0]        now_reg;

    logic [IW-1:0]  bkt_reg;
    logic [FW-1:0]  slot_reg, slot_next;
    logic [FW-1:0]  fill_cur;
    logic           found_reg, found_next;
    logic [IW-1:0]  ridx_reg, ridx_next;
    logic [1:0]     status_reg;
    logic [5:0]     bidx_reg;
    logic           ovalid_reg;

    logic           lzc_start, lzc_done;
    logic [IW-1:0]  lzc_zeros;
    logic           in_xfer, out_xfer;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic           do_write;
    logic           start_d_reg;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || ovalid_reg;
    assign cfg_ready = 1'b1;

    xdbt_lzc #(.ID_BITS(ID_BITS)) u_lzc (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lzc_start),
        .distance (id_reg ^ self_id_reg[ID_BITS-1:0]),
        .done     (lzc_done),
        .zeros    (lzc_zeros)
    );

    assign fill_cur = fill_rd_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_xfer) state_next = mode ? S_REFRESH : S_ZSCAN;
            S_ZSCAN:   if (lzc_done) state_next = S_SEARCH;
            S_SEARCH:  state_next = (slot_reg < fill_cur) ? S_CHECK : S_WRITE;
            S_CHECK:   state_next = (ident_rd_reg == id_reg) ? S_WRITE : S_SEARCH;
            S_WRITE:   state_next = S_DONE;
            S_REFRESH: if (ridx_reg == IW'(ID_BITS - 1)) state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            S_CLEAR:   if (ridx_reg == IW'(ID_BITS - 1)) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        lzc_start  = 1'b0;
        slot_next  = slot_reg;
        found_next = found_reg;
        ridx_next  = ridx_reg;
        do_write   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                slot_next  = '0;
                found_next = 1'b0;
                ridx_next  = '0;
            end
            S_ZSCAN:   lzc_start = start_d_reg;
            S_SEARCH:  ;
            S_CHECK:
            begin
                if (ident_rd_reg == id_reg)
                    found_next = 1'b1;
                else
                    slot_next = slot_reg + 1'b1;
            end
            S_WRITE:   do_write = found_reg || (fill_cur < FW'(BUCKET_DEPTH));
            S_REFRESH: ridx_next = ridx_reg + 1'b1;
            S_DONE:    ;
            S_CLEAR:   ridx_next = ridx_reg + 1'b1;
            default:   ;
        endcase
    end

    // the lzc starts in the cycle after capture so id_reg is valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_d_reg <= 1'b0;
        else
            start_d_reg <= in_xfer && !mode;
    end

    assign rd_addr = AW'(bkt_reg) * AW'(BUCKET_DEPTH) + AW'(slot_reg[DW-1:0]);
    assign wr_addr = AW'(bkt_reg) * AW'(BUCKET_DEPTH) +
                     (found_reg ? AW'(slot_reg[DW-1:0]) : AW'(fill_cur));

    // entry memory ports
    always_ff @(posedge clk)
    begin
        ident_rd_reg <= ident_mem[rd_addr];
        if (do_write)
        begin
            ident_mem[wr_addr] <= id_reg;
            addr_mem[wr_addr]  <= addr_reg;
            seed_mem[wr_addr]  <= seed_reg;
            seen_mem[wr_addr]  <= now_reg;
        end
    end

    // bucket read address: refresh walk, freshly picked bucket, or held bucket
    always_comb
    begin
        if (state_reg == S_REFRESH)
            brd_addr = ridx_reg;
        else if (lzc_done)
            brd_addr = lzc_zeros;
        else
            brd_addr = bkt_reg;
    end

    // refresh compares the bucket read in the previous cycle
    assign refresh_hit = rvalid_d_reg && (fill_rd_reg != '0) &&
                         ((now_reg - stamp_rd_reg) > refresh_age_reg);

    // bucket write control
    always_comb
    begin
        fill_we     = 1'b0;
        fill_waddr  = bkt_reg;
        fill_wdata  = fill_cur + 1'b1;
        stamp_we    = 1'b0;
        stamp_waddr = bkt_reg;
        if (state_reg == S_CLEAR)
        begin
            fill_we    = 1'b1;
            fill_waddr = ridx_reg;
            fill_wdata = '0;
        end
        else if (do_write && !found_reg)
            fill_we = 1'b1;
        if (do_write)
            stamp_we = 1'b1;
        else if (refresh_hit)
        begin
            stamp_we    = 1'b1;
            stamp_waddr = ridx_d_reg;
        end
    end

    // bucket memory ports
    always_ff @(posedge clk)
    begin
        fill_rd_reg  <= fill_mem[brd_addr];
        stamp_rd_reg <= stamp_mem[brd_addr];
        if (fill_we)
            fill_mem[fill_waddr] <= fill_wdata;
        if (stamp_we)
            stamp_mem[stamp_waddr] <= now_reg;
    end

    // item capture and bucket select
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            id_reg   <= node_id[ID_BITS-1:0];
            addr_reg <= {ip_addr, port_num};
            seed_reg <= peer_seed;
            now_reg  <= now;
        end
        if (lzc_done)
            bkt_reg <= lzc_zeros;
    end

    // control registers, table state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            self_id_reg     <= '0;
            refresh_age_reg <= REFRESH_AGE_RST;
            total_reg       <= '0;
            slot_reg        <= '0;
            found_reg       <= 1'b0;
            ridx_reg        <= '0;
            ridx_d_reg      <= '0;
            rvalid_d_reg    <= 1'b0;
            ovalid_reg      <= 1'b0;
            status_reg      <= ST_UPDATED;
            bidx_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            found_reg    <= found_next;
            ridx_reg     <= ridx_next;
            ridx_d_reg   <= ridx_reg;
            rvalid_d_reg <= (state_reg == S_REFRESH);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SELF_ID)
                    self_id_reg <= cfg_data;
                else
                    refresh_age_reg <= cfg_data[31:0];
            end
            if (state_reg == S_WRITE)
            begin
                bidx_reg <= 6'(bkt_reg);
                if (found_reg)
                    status_reg <= ST_UPDATED;
                else if (fill_cur < FW'(BUCKET_DEPTH))
                begin
                    total_reg  <= total_reg + 1'b1;
                    status_reg <= ST_INSERTED;
                end
                else
                    status_reg <= ST_FULL;
            end
            if (state_reg == S_REFRESH)
            begin
                status_reg <= ST_REFRESH;
                bidx_reg   <= '0;
            end
            if (state_reg == S_DONE)
                ovalid_reg <= 1'b1;
            else if (out_xfer)
                ovalid_reg <= 1'b0;
        end
    end

    assign out_valid    = ovalid_reg;
    assign status       = status_reg;
    assign bucket_index = bidx_reg;
    assign table_size   = total_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && !found_reg && fill_cur < FW'(BUCKET_DEPTH))
        |=> (total_reg == $past(total_reg) + 13'd1))
        else $error("total not bumped on insert");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (slot_reg < FW'(BUCKET_DEPTH)))
        else $error("search past bucket depth");

endmodule
